>>> rtl/core/mbhr_pkg.sv
// Shared types, codes and constants for the holding register responder.
package mbhr_pkg;

    localparam int REG_COUNT_DEF = 128;

    localparam logic [1:0] ACT_READ   = 2'd0;
    localparam logic [1:0] ACT_WRITE1 = 2'd1;
    localparam logic [1:0] ACT_WRITEN = 2'd2;

    localparam logic [7:0] FC_READ_HOLD   = 8'h03;
    localparam logic [7:0] FC_WRITE_ONE   = 8'h06;
    localparam logic [7:0] FC_WRITE_MANY  = 8'h10;
    localparam logic [7:0] FC_EXC_FLAG    = 8'h80;
    localparam logic [7:0] EXC_BAD_ADDR   = 8'h02;
    localparam logic [7:0] EXC_BAD_COUNT  = 8'h03;

    localparam logic [7:0] STATION_RESET = 8'd1;
    localparam logic [15:0] CRC_INIT     = 16'hFFFF;
    localparam logic [15:0] CRC_POLY     = 16'hA001;

    typedef struct packed {
        logic [1:0]  action;
        logic [15:0] start_addr;
        logic [15:0] count_or_value;
        logic [6:0]  word_index;
        logic [15:0] write_word;
        logic        last_word;
    } t_req;

    typedef struct packed {
        logic [63:0] response_chunk;
        logic [3:0]  chunk_bytes;
        logic        last_chunk;
    } t_rsp;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_BYTE,
        ST_FETCH,
        ST_WAIT
    } t_state;

    typedef enum logic [1:0] {
        FK_EXC,
        FK_READ,
        FK_WRITE
    } t_kind;

    typedef struct packed {
        logic        we;
        logic        emit;
    } t_ctl;

endpackage

>>> rtl/core/modbus_holding_register_responder.sv
// Top level: Modbus holding register responder with framing and CRC.
//
//  channel   | handshake                  | payload
//  ----------+----------------------------+---------------------------
//  request   | start in, busy out         | i_req  (mbhr_pkg::t_req)
//  response  | o_rsp_valid strobe out     | o_rsp  (mbhr_pkg::t_rsp)
//  config    | i_cfg_valid / o_cfg_ready  | i_cfg_data (station address)
//
// One frame byte per cycle goes through the shared CRC byte unit, but a read
// pauses in ST_FETCH and ST_WAIT for the RAM fetch of each register, and a
// non-final write-multiple word gets no answer. Synchronous active-low reset
// clears control and the register valid bits, so registers read as zero until
// written. Each chunk is shown for one cycle only; the receiver cannot
// stall it.
module modbus_holding_register_responder #(
    parameter int REG_COUNT = mbhr_pkg::REG_COUNT_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  mbhr_pkg::t_req   i_req,
    output logic             o_rsp_valid,
    output mbhr_pkg::t_rsp   o_rsp,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [7:0]       i_cfg_data
);

    localparam int AW = $clog2(REG_COUNT);
    localparam logic [16:0] REG_LIMIT = 17'(REG_COUNT);

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ mbhr_pkg::CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    mbhr_pkg::t_state r_state, n_state;
    mbhr_pkg::t_kind  r_kind;
    mbhr_pkg::t_req   r_req;
    mbhr_pkg::t_ctl   ctl;
    mbhr_pkg::t_rsp   r_rsp;

    logic [7:0]           r_station;
    logic [7:0]           r_func;
    logic [7:0]           r_exc_code;
    logic [8:0]           r_len;
    logic [8:0]           r_pos;
    logic [8:0]           n_pos;
    logic [15:0]          r_crc;
    logic [2:0]           r_nb;
    logic [63:0]          r_chunk;
    logic [63:0]          n_chunk;
    logic [AW-1:0]        r_raddr;
    logic [15:0]          r_word;
    logic                 r_vld_rd;
    logic [REG_COUNT-1:0] r_valid;
    logic                 r_rsp_valid;

    logic [15:0] ram_rdata;
    logic [AW-1:0] waddr;
    logic [15:0] wdata;
    logic [16:0] span;
    logic [15:0] wm_sum;
    logic        bad_cnt;
    logic        bad_addr;
    logic        bad_w1;
    logic        wm_ok;
    logic        is_last;
    logic        fetch_next;
    logic [7:0]  cur_byte;

    // request checks
    always_comb begin
        span     = {1'b0, r_req.start_addr} + {1'b0, r_req.count_or_value};
        wm_sum   = r_req.start_addr + 16'(r_req.word_index);
        bad_cnt  = (r_req.count_or_value == 16'd0) ||
                   ({1'b0, r_req.count_or_value} > REG_LIMIT);
        bad_addr = span > REG_LIMIT;
        bad_w1   = {1'b0, r_req.start_addr} >= REG_LIMIT;
        wm_ok    = !bad_cnt && !bad_addr &&
                   ({9'd0, r_req.word_index} < r_req.count_or_value);
    end

    assign n_pos      = r_pos + 9'd1;
    assign is_last    = (r_pos == r_len + 9'd1);
    assign fetch_next = (r_kind == mbhr_pkg::FK_READ) && (n_pos < r_len) &&
                        n_pos[0] && (n_pos >= 9'd3);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            mbhr_pkg::ST_IDLE: begin
                if (start) begin
                    n_state = mbhr_pkg::ST_EVAL;
                end
            end
            mbhr_pkg::ST_EVAL: begin
                if (r_req.action == mbhr_pkg::ACT_READ ||
                    r_req.action == mbhr_pkg::ACT_WRITE1 ||
                    (r_req.action == mbhr_pkg::ACT_WRITEN && r_req.last_word)) begin
                    n_state = mbhr_pkg::ST_BYTE;
                end else begin
                    n_state = mbhr_pkg::ST_IDLE;
                end
            end
            mbhr_pkg::ST_BYTE: begin
                if (is_last) begin
                    n_state = mbhr_pkg::ST_IDLE;
                end else if (fetch_next) begin
                    n_state = mbhr_pkg::ST_FETCH;
                end
            end
            mbhr_pkg::ST_FETCH: n_state = mbhr_pkg::ST_WAIT;
            mbhr_pkg::ST_WAIT:  n_state = mbhr_pkg::ST_BYTE;
            default:            n_state = mbhr_pkg::ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        ctl.we   = 1'b0;
        ctl.emit = 1'b0;
        waddr    = r_req.start_addr[AW-1:0];
        wdata    = r_req.count_or_value;
        unique case (r_state)
            mbhr_pkg::ST_EVAL: begin
                if (r_req.action == mbhr_pkg::ACT_WRITE1) begin
                    ctl.we = !bad_w1;
                end else if (r_req.action == mbhr_pkg::ACT_WRITEN) begin
                    ctl.we = wm_ok;
                    waddr  = wm_sum[AW-1:0];
                    wdata  = r_req.write_word;
                end
            end
            mbhr_pkg::ST_BYTE: ctl.emit = 1'b1;
            default: ;
        endcase
    end

    assign busy        = (r_state != mbhr_pkg::ST_IDLE);
    assign o_cfg_ready = !busy;

    // frame byte select
    always_comb begin
        cur_byte = 8'd0;
        if (r_pos == r_len) begin
            cur_byte = r_crc[7:0];
        end else if (is_last) begin
            cur_byte = r_crc[15:8];
        end else begin
            case (r_pos)
                9'd0: cur_byte = r_station;
                9'd1: cur_byte = r_func;
                9'd2: begin
                    case (r_kind)
                        mbhr_pkg::FK_EXC:  cur_byte = r_exc_code;
                        mbhr_pkg::FK_READ: cur_byte = {r_req.count_or_value[6:0], 1'b0};
                        default:           cur_byte = r_req.start_addr[15:8];
                    endcase
                end
                default: begin
                    if (r_kind == mbhr_pkg::FK_READ) begin
                        cur_byte = r_pos[0] ? r_word[15:8] : r_word[7:0];
                    end else begin
                        case (r_pos)
                            9'd3:    cur_byte = r_req.start_addr[7:0];
                            9'd4:    cur_byte = r_req.count_or_value[15:8];
                            9'd5:    cur_byte = r_req.count_or_value[7:0];
                            default: cur_byte = 8'd0;
                        endcase
                    end
                end
            endcase
        end
    end

    always_comb begin
        n_chunk = r_chunk;
        for (int l = 0; l < 8; l++) begin
            if (3'(l) == r_nb) begin
                n_chunk[63-8*l -: 8] = cur_byte;
            end
        end
    end

    mbhr_ram #(
        .WIDTH(16),
        .DEPTH(REG_COUNT)
    ) u_regs (
        .i_clk   (i_clk),
        .i_we    (ctl.we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (r_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mbhr_pkg::ST_IDLE;
            r_station   <= mbhr_pkg::STATION_RESET;
            r_valid     <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rsp_valid <= ctl.emit && (r_nb == 3'd7 || is_last);
            if (i_cfg_valid && o_cfg_ready) begin
                r_station <= i_cfg_data;
            end
            if (ctl.we) begin
                r_valid[waddr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_vld_rd <= r_valid[r_raddr];
        if (start && !busy) begin
            r_req <= i_req;
        end
        unique case (r_state)
            mbhr_pkg::ST_EVAL: begin
                r_pos   <= 9'd0;
                r_crc   <= mbhr_pkg::CRC_INIT;
                r_nb    <= 3'd0;
                r_chunk <= '0;
                r_raddr <= r_req.start_addr[AW-1:0];
                case (r_req.action)
                    mbhr_pkg::ACT_READ: begin
                        if (bad_cnt || bad_addr) begin
                            r_kind     <= mbhr_pkg::FK_EXC;
                            r_func     <= mbhr_pkg::FC_EXC_FLAG | mbhr_pkg::FC_READ_HOLD;
                            r_exc_code <= bad_cnt ? mbhr_pkg::EXC_BAD_COUNT
                                                  : mbhr_pkg::EXC_BAD_ADDR;
                            r_len      <= 9'd3;
                        end else begin
                            r_kind <= mbhr_pkg::FK_READ;
                            r_func <= mbhr_pkg::FC_READ_HOLD;
                            r_len  <= 9'd3 + {r_req.count_or_value[7:0], 1'b0};
                        end
                    end
                    mbhr_pkg::ACT_WRITE1: begin
                        if (bad_w1) begin
                            r_kind     <= mbhr_pkg::FK_EXC;
                            r_func     <= mbhr_pkg::FC_EXC_FLAG | mbhr_pkg::FC_WRITE_ONE;
                            r_exc_code <= mbhr_pkg::EXC_BAD_ADDR;
                            r_len      <= 9'd3;
                        end else begin
                            r_kind <= mbhr_pkg::FK_WRITE;
                            r_func <= mbhr_pkg::FC_WRITE_ONE;
                            r_len  <= 9'd6;
                        end
                    end
                    default: begin
                        if (bad_cnt || bad_addr) begin
                            r_kind     <= mbhr_pkg::FK_EXC;
                            r_func     <= mbhr_pkg::FC_EXC_FLAG | mbhr_pkg::FC_WRITE_MANY;
                            r_exc_code <= bad_cnt ? mbhr_pkg::EXC_BAD_COUNT
                                                  : mbhr_pkg::EXC_BAD_ADDR;
                            r_len      <= 9'd3;
                        end else begin
                            r_kind <= mbhr_pkg::FK_WRITE;
                            r_func <= mbhr_pkg::FC_WRITE_MANY;
                            r_len  <= 9'd6;
                        end
                    end
                endcase
            end
            mbhr_pkg::ST_BYTE: begin
                r_pos <= n_pos;
                if (r_pos < r_len) begin
                    r_crc <= crc_byte(r_crc, cur_byte);
                end
                if (r_nb == 3'd7 || is_last) begin
                    r_rsp.response_chunk <= n_chunk;
                    r_rsp.chunk_bytes    <= {1'b0, r_nb} + 4'd1;
                    r_rsp.last_chunk     <= is_last;
                    r_chunk              <= '0;
                    r_nb                 <= 3'd0;
                end else begin
                    r_chunk <= n_chunk;
                    r_nb    <= r_nb + 3'd1;
                end
            end
            mbhr_pkg::ST_WAIT: begin
                r_word  <= r_vld_rd ? ram_rdata : 16'd0;
                r_raddr <= r_raddr + AW'(1);
            end
            default: ;
        endcase
    end

    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

`ifndef SYNTHESIS
    a_chunk_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid |-> (o_rsp.chunk_bytes != 4'd0 && o_rsp.chunk_bytes <= 4'd8))
        else $error("chunk byte count out of range");

    a_full_chunk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_valid && !o_rsp.last_chunk) |-> (o_rsp.chunk_bytes == 4'd8))
        else $error("short chunk before end of frame");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_valid && o_rsp.last_chunk) |-> !busy)
        else $error("busy after final chunk");

    a_no_write_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.we |-> (r_state == mbhr_pkg::ST_EVAL))
        else $error("register write outside evaluation");
`endif

endmodule

>>> rtl/core/mbhr_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mbhr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> dv/tb_modbus_holding_register_responder.sv
// Testbench for the holding register responder: directed table, then random traffic.
`timescale 1ns / 1ps

module tb_modbus_holding_register_responder;

    localparam int REG_N = mbhr_pkg::REG_COUNT_DEF;
    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam logic [7:0] NO_EXC = 8'h00;
    localparam logic [7:0] FC_RD_EXC = mbhr_pkg::FC_EXC_FLAG | mbhr_pkg::FC_READ_HOLD;
    localparam logic [7:0] FC_W1_EXC = mbhr_pkg::FC_EXC_FLAG | mbhr_pkg::FC_WRITE_ONE;
    localparam logic [7:0] FC_WN_EXC = mbhr_pkg::FC_EXC_FLAG | mbhr_pkg::FC_WRITE_MANY;
    localparam int SETTLE_CYCLES = 24;

    typedef struct {
        mbhr_pkg::t_req req;
        logic [7:0]     exc_fc;
        logic [7:0]     exc_code;
    } t_row;

    logic           i_clk;
    logic           i_rst_n;
    logic           start;
    logic           busy;
    mbhr_pkg::t_req i_req;
    logic           o_rsp_valid;
    mbhr_pkg::t_rsp o_rsp;
    logic           i_cfg_valid;
    logic           o_cfg_ready;
    logic [7:0]     i_cfg_data;

    logic [15:0]    shadow_regs [REG_N];
    logic [7:0]     station_addr;
    logic [7:0]     frame_q [$];
    mbhr_pkg::t_rsp pending_chunks [$];
    mbhr_pkg::t_rsp want_chunk;
    t_row           dir_tbl [$];
    int             burst_left;
    int             error_count;

    modbus_holding_register_responder DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_req      (i_req),
        .o_rsp_valid(o_rsp_valid),
        .o_rsp      (o_rsp),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic flag_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    function automatic void push_header(input logic [7:0] b1, input logic [7:0] b2);
        frame_q.push_back(station_addr);
        frame_q.push_back(b1);
        frame_q.push_back(b2);
    endfunction

    // Fill frame_q with the answer (no CRC); return whether one is given.
    function automatic bit serve_request(input mbhr_pkg::t_req r);
        bit          bad_cnt;
        bit          bad_addr;
        logic [16:0] span;
        logic [15:0] dbl;
        logic [15:0] v;
        int          i;
        frame_q.delete();
        bad_cnt  = (r.count_or_value == 16'd0) || (r.count_or_value > REG_N);
        span     = {1'b0, r.start_addr} + {1'b0, r.count_or_value};
        bad_addr = !bad_cnt && (span > REG_N);
        case (r.action)
            mbhr_pkg::ACT_READ: begin
                if (bad_cnt) begin
                    push_header(FC_RD_EXC, mbhr_pkg::EXC_BAD_COUNT);
                end else if (bad_addr) begin
                    push_header(FC_RD_EXC, mbhr_pkg::EXC_BAD_ADDR);
                end else begin
                    dbl = r.count_or_value << 1;
                    push_header(mbhr_pkg::FC_READ_HOLD, dbl[7:0]);
                    for (i = 0; i < int'(r.count_or_value); i++) begin
                        v = shadow_regs[int'(r.start_addr) + i];
                        frame_q.push_back(v[15:8]);
                        frame_q.push_back(v[7:0]);
                    end
                end
                return 1'b1;
            end
            mbhr_pkg::ACT_WRITE1: begin
                if (r.start_addr >= REG_N) begin
                    push_header(FC_W1_EXC, mbhr_pkg::EXC_BAD_ADDR);
                end else begin
                    shadow_regs[int'(r.start_addr)] = r.count_or_value;
                    push_header(mbhr_pkg::FC_WRITE_ONE, r.start_addr[15:8]);
                    frame_q.push_back(r.start_addr[7:0]);
                    frame_q.push_back(r.count_or_value[15:8]);
                    frame_q.push_back(r.count_or_value[7:0]);
                end
                return 1'b1;
            end
            mbhr_pkg::ACT_WRITEN: begin
                if (!bad_cnt && !bad_addr && r.word_index < r.count_or_value) begin
                    shadow_regs[int'(r.start_addr) + int'(r.word_index)] = r.write_word;
                end
                if (!r.last_word) begin
                    return 1'b0;
                end
                if (bad_cnt) begin
                    push_header(FC_WN_EXC, mbhr_pkg::EXC_BAD_COUNT);
                end else if (bad_addr) begin
                    push_header(FC_WN_EXC, mbhr_pkg::EXC_BAD_ADDR);
                end else begin
                    push_header(mbhr_pkg::FC_WRITE_MANY, r.start_addr[15:8]);
                    frame_q.push_back(r.start_addr[7:0]);
                    frame_q.push_back(r.count_or_value[15:8]);
                    frame_q.push_back(r.count_or_value[7:0]);
                end
                return 1'b1;
            end
            default: begin
                return 1'b0;
            end
        endcase
    endfunction

    // Append CRC, cut frame_q into chunks of up to 8 bytes.
    function automatic void frame_to_chunks();
        logic [15:0]    crc;
        mbhr_pkg::t_rsp c;
        int             pos;
        int             n;
        int             k;
        int             b;
        crc = mbhr_pkg::CRC_INIT;
        for (k = 0; k < frame_q.size(); k++) begin
            crc ^= {8'h00, frame_q[k]};
            for (b = 0; b < 8; b++) begin
                crc = crc[0] ? ((crc >> 1) ^ mbhr_pkg::CRC_POLY) : (crc >> 1);
            end
        end
        frame_q.push_back(crc[7:0]);
        frame_q.push_back(crc[15:8]);
        pos = 0;
        while (pos < frame_q.size()) begin
            n = frame_q.size() - pos;
            if (n > 8) begin
                n = 8;
            end
            c = '0;
            for (k = 0; k < n; k++) begin
                c.response_chunk[63 - 8 * k -: 8] = frame_q[pos + k];
            end
            pos += n;
            c.chunk_bytes = 4'(n);
            c.last_chunk  = (pos >= frame_q.size());
            pending_chunks.push_back(c);
        end
    endfunction

    task automatic issue(input mbhr_pkg::t_req r, input logic [7:0] exc_fc,
                         input logic [7:0] exc_code);
        int gap;
        bit answers;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                start <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 10);
        end
        burst_left--;
        i_req <= r;
        start <= 1'b1;
        do @(negedge i_clk); while (busy !== 1'b0);
        @(posedge i_clk);
        answers = serve_request(r);
        if (exc_fc != NO_EXC) begin
            frame_q.delete();
            push_header(exc_fc, exc_code);
        end
        if (answers) begin
            frame_to_chunks();
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        while (pending_chunks.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        burst_left = 0;
    endtask

    task automatic set_station(input logic [7:0] v);
        i_cfg_data  <= v;
        i_cfg_valid <= 1'b1;
        do @(negedge i_clk); while (o_cfg_ready !== 1'b1);
        @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        station_addr = v;
    endtask

    function automatic t_row row(input logic [1:0] act, input logic [15:0] addr,
                                 input logic [15:0] cv, input logic [6:0] idx,
                                 input logic [15:0] w, input logic lst,
                                 input logic [7:0] efc, input logic [7:0] ecode);
        t_row t;
        t.req.action         = act;
        t.req.start_addr     = addr;
        t.req.count_or_value = cv;
        t.req.word_index     = idx;
        t.req.write_word     = w;
        t.req.last_word      = lst;
        t.exc_fc             = efc;
        t.exc_code           = ecode;
        return t;
    endfunction

    task automatic random_traffic(input int target);
        int             done_n;
        int             pick;
        int             cnt;
        int             addr;
        int             nw;
        int             k;
        mbhr_pkg::t_req r;
        done_n = 0;
        while (done_n < target) begin
            pick = $urandom_range(0, 99);
            r.action         = mbhr_pkg::ACT_READ;
            r.start_addr     = 16'($urandom_range(0, 16'hFFFF));
            r.count_or_value = 16'($urandom_range(0, 16'hFFFF));
            r.word_index     = 7'($urandom_range(0, 127));
            r.write_word     = 16'($urandom_range(0, 16'hFFFF));
            r.last_word      = 1'($urandom_range(0, 1));
            if (pick < 30) begin
                cnt = ($urandom_range(0, 24) == 0) ? $urandom_range(9, REG_N)
                                                   : $urandom_range(1, 8);
                r.count_or_value = 16'(cnt);
                r.start_addr     = 16'($urandom_range(0, REG_N - cnt));
                issue(r, NO_EXC, NO_EXC);
                done_n++;
            end else if (pick < 50) begin
                r.action     = mbhr_pkg::ACT_WRITE1;
                r.start_addr = 16'($urandom_range(0, REG_N - 1));
                issue(r, NO_EXC, NO_EXC);
                done_n++;
            end else if (pick < 80) begin
                cnt  = $urandom_range(1, 8);
                addr = $urandom_range(0, REG_N - cnt);
                for (k = 0; k < cnt; k++) begin
                    r.action         = mbhr_pkg::ACT_WRITEN;
                    r.start_addr     = 16'(addr);
                    r.count_or_value = 16'(cnt);
                    r.word_index     = 7'(k);
                    r.write_word     = 16'($urandom_range(0, 16'hFFFF));
                    r.last_word      = (k == cnt - 1);
                    issue(r, NO_EXC, NO_EXC);
                    done_n++;
                end
            end else if (pick < 88) begin
                cnt  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 16'hFFFF)
                                                   : $urandom_range(0, REG_N + 2);
                addr = ($urandom_range(0, 1) == 0) ? $urandom_range(0, REG_N)
                                                   : $urandom_range(0, 16'hFFFF);
                nw   = $urandom_range(1, 4);
                for (k = 0; k < nw; k++) begin
                    r.action         = mbhr_pkg::ACT_WRITEN;
                    r.start_addr     = 16'(addr);
                    r.count_or_value = 16'(cnt);
                    r.word_index     = ($urandom_range(0, 1) == 0) ? 7'(k)
                                                                   : 7'($urandom_range(0, 127));
                    r.write_word     = 16'($urandom_range(0, 16'hFFFF));
                    r.last_word      = (k == nw - 1) && ($urandom_range(0, 3) != 0);
                    issue(r, NO_EXC, NO_EXC);
                    done_n++;
                end
            end else if (pick < 96) begin
                r.action = 2'($urandom_range(0, 2));
                issue(r, NO_EXC, NO_EXC);
                done_n++;
            end else begin
                r.action = ACT_UNUSED;
                issue(r, NO_EXC, NO_EXC);
            end
            if ($urandom_range(0, 40) == 0) begin
                drain();
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_rsp_valid === 1'b1) begin
            if (pending_chunks.size() == 0) begin
                flag_mismatch("unexpected chunk", o_rsp.response_chunk, '0);
            end else begin
                want_chunk = pending_chunks.pop_front();
                if (o_rsp.response_chunk !== want_chunk.response_chunk) begin
                    flag_mismatch("response_chunk", o_rsp.response_chunk,
                                  want_chunk.response_chunk);
                end
                if (o_rsp.chunk_bytes !== want_chunk.chunk_bytes) begin
                    flag_mismatch("chunk_bytes", 64'(o_rsp.chunk_bytes),
                                  64'(want_chunk.chunk_bytes));
                end
                if (o_rsp.last_chunk !== want_chunk.last_chunk) begin
                    flag_mismatch("last_chunk", 64'(o_rsp.last_chunk),
                                  64'(want_chunk.last_chunk));
                end
            end
        end
    end

    initial begin
        #5_000_000;
        $display("status: fail");
        $finish;
    end

    initial begin
        i_clk        = 1'b0;
        i_rst_n      = 1'b0;
        start        = 1'b0;
        i_req        = '0;
        i_cfg_valid  = 1'b0;
        i_cfg_data   = 8'h00;
        burst_left   = 0;
        error_count  = 0;
        station_addr = mbhr_pkg::STATION_RESET;
        foreach (shadow_regs[k]) begin
            shadow_regs[k] = 16'h0000;
        end

        dir_tbl.push_back(row(mbhr_pkg::ACT_READ, 0, 1, 0, 0, 1, NO_EXC, NO_EXC));
        dir_tbl.push_back(row(mbhr_pkg::ACT_READ, 0, 0, 127, 16'hFFFF, 1,
                              FC_RD_EXC, mbhr_pkg::EXC_BAD_COUNT));
        dir_tbl.push_back(row(mbhr_pkg::ACT_READ, 0, 129, 0, 0, 1,
                              FC_RD_EXC, mbhr_pkg::EXC_BAD_COUNT));
        dir_tbl.push_back(row(mbhr_pkg::ACT_READ, 16'hFFFF, 16'hFFFF, 0, 0, 0,
                              FC_RD_EXC, mbhr_pkg::EXC_BAD_COUNT));
        dir_tbl.push_back(row(mbhr_pkg::ACT_READ, 127, 2, 0, 0, 1,
                              FC_RD_EXC, mbhr_pkg::EXC_BAD_ADDR));
        dir_tbl.push_back(row(mbhr_pkg::ACT_READ, 16'hFFFF, 1, 0, 0, 1,
                              FC_RD_EXC, mbhr_pkg::EXC_BAD_ADDR));
        dir_tbl.push_back(row(mbhr_pkg::ACT_WRITE1, 0, 16'hFFFF, 0, 0, 1, NO_EXC, NO_EXC));
        dir_tbl.push_back(row(mbhr_pkg::ACT_WRITE1, 127, 16'h8001, 0, 0, 0, NO_EXC, NO_EXC));
        dir_tbl.push_back(row(mbhr_pkg::ACT_WRITE1, 128, 16'h0005, 0, 0, 1,
                              FC_W1_EXC, mbhr_pkg::EXC_BAD_ADDR));
        dir_tbl.push_back(row(mbhr_pkg::ACT_WRITE1, 16'hFFFF, 0, 0, 0, 1,
                              FC_W1_EXC, mbhr_pkg::EXC_BAD_ADDR));
        dir_tbl.push_back(row(mbhr_pkg::ACT_WRITEN, 125, 3, 0, 16'hA5A5, 0, NO_EXC, NO_EXC));
        dir_tbl.push_back(row(mbhr_pkg::ACT_WRITEN, 125, 3, 1, 16'h5A5A, 0, NO_EXC, NO_EXC));
        dir_tbl.push_back(row(mbhr_pkg::ACT_WRITEN, 125, 3, 2, 16'hFFFF, 1, NO_EXC, NO_EXC));
        dir_tbl.push_back(row(mbhr_pkg::ACT_WRITEN, 0, 2, 5, 16'h1234, 0, NO_EXC, NO_EXC));
        dir_tbl.push_back(row(mbhr_pkg::ACT_WRITEN, 0, 2, 127, 16'h4321, 1, NO_EXC, NO_EXC));
        dir_tbl.push_back(row(mbhr_pkg::ACT_WRITEN, 0, 0, 0, 16'h0001, 1,
                              FC_WN_EXC, mbhr_pkg::EXC_BAD_COUNT));
        dir_tbl.push_back(row(mbhr_pkg::ACT_WRITEN, 0, 129, 0, 16'h0001, 1,
                              FC_WN_EXC, mbhr_pkg::EXC_BAD_COUNT));
        dir_tbl.push_back(row(mbhr_pkg::ACT_WRITEN, 100, 29, 0, 16'hDEAD, 1,
                              FC_WN_EXC, mbhr_pkg::EXC_BAD_ADDR));
        dir_tbl.push_back(row(mbhr_pkg::ACT_WRITEN, 16'hFFFF, 1, 0, 16'hBEEF, 0,
                              NO_EXC, NO_EXC));
        dir_tbl.push_back(row(ACT_UNUSED, 0, 1, 0, 0, 1, NO_EXC, NO_EXC));
        dir_tbl.push_back(row(mbhr_pkg::ACT_READ, 0, 128, 0, 0, 0, NO_EXC, NO_EXC));
        dir_tbl.push_back(row(mbhr_pkg::ACT_READ, 120, 8, 0, 0, 1, NO_EXC, NO_EXC));
        dir_tbl.push_back(row(mbhr_pkg::ACT_READ, 125, 3, 0, 0, 1, NO_EXC, NO_EXC));

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_tbl[k]) begin
            issue(dir_tbl[k].req, dir_tbl[k].exc_fc, dir_tbl[k].exc_code);
        end

        drain();
        set_station(8'h00);
        random_traffic(30);
        drain();
        set_station(8'hFF);
        random_traffic(28);
        drain();
        set_station(8'($urandom_range(0, 255)));
        random_traffic(28);
        drain();

        if (error_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/core/mbhr_pkg.sv
rtl/core/mbhr_ram.sv
rtl/core/modbus_holding_register_responder.sv
dv/tb_modbus_holding_register_responder.sv
